FILE: src/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: src/fcgi_pkg.sv
// ---------------------------------------------------------------------------
// fcgi_pkg
// Types and constants for the record deframer.
// ---------------------------------------------------------------------------
package fcgi_pkg;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned REQ_W  = 16;
    localparam int unsigned LEN_W  = 16;
    localparam int unsigned KIND_W = 3;

    localparam logic [BYTE_W-1:0] VERSION_ONE = 8'd1;

    // Header walk: one phase per header byte, then content, padding, halt.
    typedef enum logic [3:0] {
        PH_VERSION  = 4'd0,
        PH_TYPE     = 4'd1,
        PH_REQ_HI   = 4'd2,
        PH_REQ_LO   = 4'd3,
        PH_LEN_HI   = 4'd4,
        PH_LEN_LO   = 4'd5,
        PH_PAD      = 4'd6,
        PH_RESERVED = 4'd7,
        PH_CONTENT  = 4'd8,
        PH_PADDING  = 4'd9,
        PH_HALTED   = 4'd10
    } phase_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_CONTENT   = 3'd0,
        KIND_EMPTY     = 3'd1,
        KIND_BAD_VER   = 3'd2,
        KIND_TRUNCATED = 3'd3,
        KIND_CLEAN_END = 3'd4
    } kind_t;

endpackage

FILE: src/fastcgi_record_deframer.sv
// ---------------------------------------------------------------------------
// fastcgi_record_deframer
// Splits a connection byte stream into tagged record content bytes.
// ---------------------------------------------------------------------------
// Input channel (s_): one stream byte per item in s_tdata; s_tlast high marks
// the close of the stream, the data byte is then ignored.
// Output channel (m_): one result per item that produces one. m_tuser holds
// the result kind (content byte, empty record, bad version, truncated, clean
// end); m_tdata holds record type, request id and content byte; m_tlast marks
// the final content byte of a record or the empty-record result.
// Header bytes and padding bytes are consumed without a result.
// Each item is taken into the input register, decoded from there, and its result
// is registered in the result register that drives m_tvalid.
// Throughput: one item per cycle while m_tready does not stall the result side,
// set by the header state machine that sits between the input and result registers.
// Reset (aresetn low, synchronous) returns the walker to the version byte and
// empties both registers. After a bad version, a truncation or a clean end the
// block keeps accepting items but drops them until reset.
// When m_tready is low with a result pending, the decode stage holds and
// s_tready drops once the input register is also full; nothing is lost.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fastcgi_record_deframer (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // stream_end
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [7:0] record_kind, [23:8] request_number,
                                   // [31:24] payload_byte
    output logic [2:0]  m_tuser,   // [2:0] kind
    output logic        m_tlast    // last_of_record
);

    // input register
    logic                           in_valid_reg;
    logic [fcgi_pkg::BYTE_W-1:0]    in_byte_reg;
    logic                           in_end_reg;

    // walker state
    fcgi_pkg::phase_t               phase_reg, phase_next;
    logic [fcgi_pkg::BYTE_W-1:0]    held_type_reg, held_type_next;
    logic [fcgi_pkg::REQ_W-1:0]     held_request_reg, held_request_next;
    logic [fcgi_pkg::LEN_W-1:0]     content_left_reg, content_left_next;
    logic [fcgi_pkg::BYTE_W-1:0]    padding_left_reg, padding_left_next;

    // result register
    logic                           out_valid_reg;
    fcgi_pkg::kind_t                out_kind_reg;
    logic [fcgi_pkg::BYTE_W-1:0]    out_type_reg;
    logic [fcgi_pkg::REQ_W-1:0]     out_request_reg;
    logic [fcgi_pkg::BYTE_W-1:0]    out_byte_reg;
    logic                           out_last_reg;

    // decode results
    logic                           res_valid;
    fcgi_pkg::kind_t                res_kind;
    logic [fcgi_pkg::BYTE_W-1:0]    res_type;
    logic [fcgi_pkg::REQ_W-1:0]     res_request;
    logic [fcgi_pkg::BYTE_W-1:0]    res_byte;
    logic                           res_last;

    logic                           proc_fire;
    fcgi_pkg::phase_t               after_content;

    // Decode stage advances when the result register can take a new value.
    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    assign after_content = (padding_left_reg != '0) ? fcgi_pkg::PH_PADDING
                                                    : fcgi_pkg::PH_VERSION;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    always_comb begin
        phase_next        = phase_reg;
        held_type_next    = held_type_reg;
        held_request_next = held_request_reg;
        content_left_next = content_left_reg;
        padding_left_next = padding_left_reg;
        res_valid         = 1'b0;
        res_kind          = fcgi_pkg::KIND_CONTENT;
        res_type          = '0;
        res_request       = '0;
        res_byte          = '0;
        res_last          = 1'b0;

        if (phase_reg != fcgi_pkg::PH_HALTED) begin
            if (in_end_reg) begin
                res_valid  = 1'b1;
                res_kind   = (phase_reg == fcgi_pkg::PH_VERSION) ? fcgi_pkg::KIND_CLEAN_END
                                                                 : fcgi_pkg::KIND_TRUNCATED;
                phase_next = fcgi_pkg::PH_HALTED;
            end else begin
                case (phase_reg)
                    fcgi_pkg::PH_VERSION: begin
                        if (in_byte_reg != fcgi_pkg::VERSION_ONE) begin
                            res_valid  = 1'b1;
                            res_kind   = fcgi_pkg::KIND_BAD_VER;
                            phase_next = fcgi_pkg::PH_HALTED;
                        end else begin
                            phase_next = fcgi_pkg::PH_TYPE;
                        end
                    end
                    fcgi_pkg::PH_TYPE: begin
                        held_type_next = in_byte_reg;
                        phase_next     = fcgi_pkg::PH_REQ_HI;
                    end
                    fcgi_pkg::PH_REQ_HI: begin
                        held_request_next = {in_byte_reg, 8'h00};
                        phase_next        = fcgi_pkg::PH_REQ_LO;
                    end
                    fcgi_pkg::PH_REQ_LO: begin
                        held_request_next = {held_request_reg[15:8], in_byte_reg};
                        phase_next        = fcgi_pkg::PH_LEN_HI;
                    end
                    fcgi_pkg::PH_LEN_HI: begin
                        content_left_next = {in_byte_reg, 8'h00};
                        phase_next        = fcgi_pkg::PH_LEN_LO;
                    end
                    fcgi_pkg::PH_LEN_LO: begin
                        content_left_next = {content_left_reg[15:8], in_byte_reg};
                        phase_next        = fcgi_pkg::PH_PAD;
                    end
                    fcgi_pkg::PH_PAD: begin
                        padding_left_next = in_byte_reg;
                        phase_next        = fcgi_pkg::PH_RESERVED;
                    end
                    fcgi_pkg::PH_RESERVED: begin
                        if (content_left_reg != '0) begin
                            phase_next = fcgi_pkg::PH_CONTENT;
                        end else begin
                            // empty record reported before any padding
                            res_valid   = 1'b1;
                            res_kind    = fcgi_pkg::KIND_EMPTY;
                            res_type    = held_type_reg;
                            res_request = held_request_reg;
                            res_last    = 1'b1;
                            phase_next  = after_content;
                        end
                    end
                    fcgi_pkg::PH_CONTENT: begin
                        content_left_next = content_left_reg - 16'd1;
                        res_valid         = 1'b1;
                        res_kind          = fcgi_pkg::KIND_CONTENT;
                        res_type          = held_type_reg;
                        res_request       = held_request_reg;
                        res_byte          = in_byte_reg;
                        res_last          = (content_left_reg == 16'd1);
                        if (content_left_reg == 16'd1) begin
                            phase_next = after_content;
                        end
                    end
                    fcgi_pkg::PH_PADDING: begin
                        padding_left_next = padding_left_reg - 8'd1;
                        if (padding_left_reg == 8'd1) begin
                            phase_next = fcgi_pkg::PH_VERSION;
                        end
                    end
                    default: begin
                        phase_next = fcgi_pkg::PH_HALTED;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= fcgi_pkg::PH_VERSION;
            held_type_reg    <= '0;
            held_request_reg <= '0;
            content_left_reg <= '0;
            padding_left_reg <= '0;
        end else if (proc_fire) begin
            phase_reg        <= phase_next;
            held_type_reg    <= held_type_next;
            held_request_reg <= held_request_next;
            content_left_reg <= content_left_next;
            padding_left_reg <= padding_left_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc_fire && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (proc_fire && res_valid) begin
            out_kind_reg    <= res_kind;
            out_type_reg    <= res_type;
            out_request_reg <= res_request;
            out_byte_reg    <= res_byte;
            out_last_reg    <= res_last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {out_byte_reg, out_request_reg, out_type_reg};
    assign m_tlast  = out_last_reg;

    // once halted with nothing pending, no further result appears
    `ASSERT_NEXT(a_halt_silent, aclk, aresetn,
        (phase_reg == fcgi_pkg::PH_HALTED) && !out_valid_reg, !out_valid_reg)
    // terminal results are only produced on the way into the halt state
    `ASSERT_IMPLY(a_term_halts, aclk, aresetn,
        out_valid_reg && (out_kind_reg == fcgi_pkg::KIND_BAD_VER ||
        out_kind_reg == fcgi_pkg::KIND_TRUNCATED || out_kind_reg == fcgi_pkg::KIND_CLEAN_END),
        phase_reg == fcgi_pkg::PH_HALTED)
    // empty-record result always closes its record
    `ASSERT_IMPLY(a_empty_last, aclk, aresetn,
        out_valid_reg && (out_kind_reg == fcgi_pkg::KIND_EMPTY), out_last_reg)
    // content phase never runs with nothing left to pass
    `ASSERT_IMPLY(a_content_nonzero, aclk, aresetn,
        phase_reg == fcgi_pkg::PH_CONTENT, content_left_reg != '0)

endmodule
